// ----- sv/wlc_pkg.sv -----
// shared constants, types and register indexes of the windowed line convolution
`timescale 1ns / 1ps
`default_nettype none
package wlc_pkg;

  localparam int LINE_MAX   = 512;
  localparam int ADDR_W     = $clog2(LINE_MAX);
  localparam int LEN_W      = ADDR_W + 1;
  localparam int POS_W      = LEN_W + 1;
  localparam int OUT_POS_W  = 9;
  localparam int HW_W       = 2;
  localparam int MAX_HW     = 3;
  localparam int MAX_WINDOW = 48;
  localparam int NUM_TAPS   = 2 * MAX_HW + 1;
  localparam int TAP_IDX_W  = $clog2(NUM_TAPS);
  localparam int DOFS_W     = HW_W + 1;
  localparam int SAMPLE_W   = 16;
  localparam int TAP_W      = 16;
  localparam int PROD_W     = SAMPLE_W + TAP_W;
  localparam int ACC_W      = PROD_W + $clog2(NUM_TAPS);
  localparam int START_W    = 10;
  localparam int WIDTH_W    = 6;
  localparam int FRAC_SHIFT = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [TAP_W-1:0]     TAP_ONE    = TAP_W'(1 << FRAC_SHIFT);
  localparam logic [ACC_W:0]       ROUND_BIAS = (ACC_W + 1)'(1 << (FRAC_SHIFT - 1));
  localparam logic [SAMPLE_W-1:0]  SAT_MAX    = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_MINUS3 = 3'd1;

  // request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_RUN  = 1'b1;

  typedef struct packed {
    logic clear;
    logic en;
  } mac_ctrl_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_READ  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_EMIT  = 5'b10000
  } state_e;

endpackage
`default_nettype wire

// ----- sv/wlc_if.sv -----
// request and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface wlc_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 req_type;
  logic [wlc_pkg::SAMPLE_W-1:0]         sample_value;
  logic                                 load_last;
  logic signed [wlc_pkg::START_W-1:0]   window_start;
  logic [wlc_pkg::WIDTH_W-1:0]          active_width;

  modport source (output valid, req_type, sample_value, load_last, window_start,
                  active_width, input ready);
  modport sink (input valid, req_type, sample_value, load_last, window_start,
                active_width, output ready);
endinterface

interface wlc_res_if;
  logic                              valid;
  logic                              ready;
  logic [wlc_pkg::OUT_POS_W-1:0]     position;
  logic [wlc_pkg::SAMPLE_W-1:0]      filtered_value;
  logic                              run_last;
  logic                              run_empty;

  modport source (output valid, position, filtered_value, run_last, run_empty,
                  input ready);
  modport sink (input valid, position, filtered_value, run_last, run_empty,
                output ready);
endinterface
`default_nettype wire

// ----- sv/windowed_line_convolution.sv -----
// top level: line loading, window sequencer and result register
`timescale 1ns / 1ps
`default_nettype none
// Load beats write one sample each until the line store is full and leave the
// input ready. A run beat first passes the check state, then each in-line
// position steps through 2*half_width+1 taps on the single multiply-accumulate
// unit, drains its pipeline and rounds the sum; the result side can stall it.
// A window with no in-line position gives one empty beat after the setup.
// The input is not ready while a run is in progress.
module windowed_line_convolution (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  wlc_req_if.sink                              req,
  wlc_res_if.source                            res,
  input  wire logic                            cfg_we_i,
  input  wire logic [wlc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [wlc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int POS_W  = wlc_pkg::POS_W;
  localparam int LEN_W  = wlc_pkg::LEN_W;
  localparam int DOFS_W = wlc_pkg::DOFS_W;

  // configuration
  logic [wlc_pkg::HW_W-1:0]  half_width_q;
  logic [wlc_pkg::TAP_W-1:0] taps_q [wlc_pkg::NUM_TAPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q <= '0;
      for (int i = 0; i < wlc_pkg::NUM_TAPS; i++) begin
        taps_q[i] <= (i == wlc_pkg::MAX_HW) ? wlc_pkg::TAP_ONE : '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == wlc_pkg::CFG_HALF_WIDTH) begin
        half_width_q <= cfg_data_i[wlc_pkg::HW_W-1:0];
      end else begin
        taps_q[wlc_pkg::TAP_IDX_W'(cfg_idx_i - wlc_pkg::CFG_TAP_MINUS3)] <=
          cfg_data_i[wlc_pkg::TAP_W-1:0];
      end
    end
  end

  // state
  wlc_pkg::state_e state_q, state_d;
  logic                 req_hs;
  logic                 load_hs;
  logic                 run_hs;
  logic                 out_free;

  assign req.ready = (state_q == wlc_pkg::S_IDLE);
  assign req_hs    = req.valid && req.ready;
  assign load_hs   = req_hs && (req.req_type == wlc_pkg::REQ_LOAD);
  assign run_hs    = req_hs && (req.req_type == wlc_pkg::REQ_RUN);

  // line loading
  logic [LEN_W-1:0] load_ptr_q, load_ptr_d;
  logic [LEN_W-1:0] line_len_q, line_len_d;
  logic             ptr_full;
  logic [LEN_W-1:0] ptr_inc;
  logic             mem_we;

  assign ptr_full = (load_ptr_q == LEN_W'(wlc_pkg::LINE_MAX));
  assign ptr_inc  = load_ptr_q + LEN_W'(!ptr_full);
  assign mem_we   = load_hs && !ptr_full;

  always_comb begin
    load_ptr_d = load_ptr_q;
    line_len_d = line_len_q;
    if (load_hs) begin
      if (req.load_last) begin
        line_len_d = ptr_inc;
        load_ptr_d = '0;
      end else begin
        load_ptr_d = ptr_inc;
      end
    end
  end

  // window bounds
  logic signed [POS_W-1:0] start_ext, hw_ext, w_ext, len_ext;
  logic signed [POS_W-1:0] first_raw, end_raw;
  logic signed [POS_W-1:0] first_q, first_d, end_q, end_d;
  logic [wlc_pkg::WIDTH_W-1:0] w_clamp;

  assign start_ext = POS_W'(req.window_start);
  assign hw_ext    = $signed(POS_W'(half_width_q));
  assign w_clamp   = (req.active_width > wlc_pkg::WIDTH_W'(wlc_pkg::MAX_WINDOW))
                     ? wlc_pkg::WIDTH_W'(wlc_pkg::MAX_WINDOW) : req.active_width;
  assign w_ext     = $signed(POS_W'(w_clamp));
  assign len_ext   = $signed(POS_W'(line_len_q));
  assign first_raw = start_ext - hw_ext;
  assign end_raw   = start_ext + hw_ext + w_ext;
  assign first_d   = (first_raw < 0) ? '0 : first_raw;
  assign end_d     = (end_raw < len_ext) ? end_raw : len_ext;

  // tap walk
  logic signed [POS_W-1:0]  n_q, n_d;
  logic signed [DOFS_W-1:0] d_q, d_d;
  logic signed [DOFS_W-1:0] d_first, d_end;
  logic signed [POS_W-1:0]  k;
  logic                     k_ok;
  logic [wlc_pkg::TAP_IDX_W-1:0] tap_idx;
  logic [wlc_pkg::TAP_W-1:0]     tap_q;
  logic                          rd_en_q;
  logic                          drain_q, drain_d;
  logic                          issue;
  logic                          last_pos;

  assign d_end    = $signed(DOFS_W'(half_width_q));
  assign d_first  = -d_end;
  assign k        = n_q + POS_W'(d_q);
  assign k_ok     = (k >= 0) && (k < len_ext);
  assign tap_idx  = wlc_pkg::TAP_IDX_W'($unsigned(d_q)) + wlc_pkg::TAP_IDX_W'(wlc_pkg::MAX_HW);
  assign issue    = (state_q == wlc_pkg::S_READ);
  assign last_pos = (n_q == end_q - POS_W'(1));

  always_ff @(posedge clk_i) begin
    tap_q <= taps_q[tap_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_en_q <= 1'b0;
    end else begin
      rd_en_q <= issue && k_ok;
    end
  end

  logic [wlc_pkg::SAMPLE_W-1:0] rd_data;

  wlc_line_mem u_line_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (load_ptr_q[wlc_pkg::ADDR_W-1:0]),
    .wdata_i (req.sample_value),
    .raddr_i (k[wlc_pkg::ADDR_W-1:0]),
    .rdata_o (rd_data)
  );

  wlc_pkg::mac_ctrl_t          mac_ctrl;
  logic [wlc_pkg::ACC_W-1:0]   acc;
  logic                        acc_clear;

  assign mac_ctrl.clear = acc_clear;
  assign mac_ctrl.en    = rd_en_q;

  wlc_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .sample_i (rd_data),
    .tap_i    (tap_q),
    .acc_o    (acc)
  );

  // rounding and saturation
  logic [wlc_pkg::ACC_W:0]      rounded;
  logic [wlc_pkg::ACC_W:0]      shifted;
  logic [wlc_pkg::SAMPLE_W-1:0] sat_val;

  assign rounded = {1'b0, acc} + wlc_pkg::ROUND_BIAS;
  assign shifted = rounded >> wlc_pkg::FRAC_SHIFT;
  assign sat_val = (shifted > (wlc_pkg::ACC_W + 1)'(wlc_pkg::SAT_MAX))
                   ? wlc_pkg::SAT_MAX : shifted[wlc_pkg::SAMPLE_W-1:0];

  // result register
  logic                          out_valid_q, out_valid_d;
  logic [wlc_pkg::OUT_POS_W-1:0] out_pos_q, out_pos_d;
  logic [wlc_pkg::SAMPLE_W-1:0]  out_val_q, out_val_d;
  logic                          out_last_q, out_last_d;
  logic                          out_empty_q, out_empty_d;

  assign out_free = !out_valid_q || res.ready;

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    d_d         = d_q;
    drain_d     = drain_q;
    acc_clear   = 1'b0;
    out_valid_d = out_valid_q && !res.ready;
    out_pos_d   = out_pos_q;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;
    unique case (state_q)
      wlc_pkg::S_IDLE: begin
        if (run_hs) begin
          state_d = wlc_pkg::S_CHECK;
        end
      end
      wlc_pkg::S_CHECK: begin
        if (first_q >= end_q) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_pos_d   = '0;
            out_val_d   = '0;
            out_last_d  = 1'b0;
            out_empty_d = 1'b1;
            state_d     = wlc_pkg::S_IDLE;
          end
        end else begin
          n_d       = first_q;
          d_d       = d_first;
          acc_clear = 1'b1;
          state_d   = wlc_pkg::S_READ;
        end
      end
      wlc_pkg::S_READ: begin
        d_d = d_q + DOFS_W'(1);
        if (d_q == d_end) begin
          drain_d = 1'b0;
          state_d = wlc_pkg::S_DRAIN;
        end
      end
      wlc_pkg::S_DRAIN: begin
        drain_d = 1'b1;
        if (drain_q) begin
          state_d = wlc_pkg::S_EMIT;
        end
      end
      wlc_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pos_d   = n_q[wlc_pkg::OUT_POS_W-1:0];
          out_val_d   = sat_val;
          out_last_d  = last_pos;
          out_empty_d = 1'b0;
          if (last_pos) begin
            state_d = wlc_pkg::S_IDLE;
          end else begin
            n_d       = n_q + POS_W'(1);
            d_d       = d_first;
            acc_clear = 1'b1;
            state_d   = wlc_pkg::S_READ;
          end
        end
      end
      default: begin
        state_d = wlc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wlc_pkg::S_IDLE;
      load_ptr_q  <= '0;
      line_len_q  <= '0;
      out_valid_q <= 1'b0;
      drain_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_ptr_q  <= load_ptr_d;
      line_len_q  <= line_len_d;
      out_valid_q <= out_valid_d;
      drain_q     <= drain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    d_q         <= d_d;
    out_pos_q   <= out_pos_d;
    out_val_q   <= out_val_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
    if (run_hs) begin
      first_q <= first_d;
      end_q   <= end_d;
    end
  end

  assign res.valid          = out_valid_q;
  assign res.position       = out_pos_q;
  assign res.filtered_value = out_val_q;
  assign res.run_last       = out_last_q;
  assign res.run_empty      = out_empty_q;

endmodule
`default_nettype wire

// ----- sv/wlc_line_mem.sv -----
// line sample memory, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module wlc_line_mem (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [wlc_pkg::ADDR_W-1:0]    waddr_i,
  input  wire logic [wlc_pkg::SAMPLE_W-1:0]  wdata_i,
  input  wire logic [wlc_pkg::ADDR_W-1:0]    raddr_i,
  output logic      [wlc_pkg::SAMPLE_W-1:0]  rdata_o
);

  logic [wlc_pkg::SAMPLE_W-1:0] mem_q [wlc_pkg::LINE_MAX];
  logic [wlc_pkg::SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- sv/wlc_mac.sv -----
// shared multiply-accumulate unit, registered product then accumulate
`timescale 1ns / 1ps
`default_nettype none
module wlc_mac (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire wlc_pkg::mac_ctrl_t            ctrl_i,
  input  wire logic [wlc_pkg::SAMPLE_W-1:0]  sample_i,
  input  wire logic [wlc_pkg::TAP_W-1:0]     tap_i,
  output logic      [wlc_pkg::ACC_W-1:0]     acc_o
);

  logic [wlc_pkg::PROD_W-1:0] prod_q, prod_d;
  logic                       prod_en_q;
  logic [wlc_pkg::ACC_W-1:0]  acc_q, acc_d;

  assign prod_d = ctrl_i.en ? (sample_i * tap_i) : '0;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (prod_en_q) begin
      acc_d = acc_q + wlc_pkg::ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_en_q <= 1'b0;
      acc_q     <= '0;
    end else begin
      prod_en_q <= ctrl_i.en;
      acc_q     <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign acc_o = acc_q;

endmodule
`default_nettype wire

// ----- sv/wlc_checker.sv -----
// port-level checks of the windowed line convolution and their bind
`timescale 1ns / 1ps
`default_nettype none
module wlc_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                req_valid,
  input wire logic                                req_ready,
  input wire logic                                req_type,
  input wire logic                                res_valid,
  input wire logic                                res_ready,
  input wire logic [wlc_pkg::OUT_POS_W-1:0]       res_position,
  input wire logic [wlc_pkg::SAMPLE_W-1:0]        res_filtered_value,
  input wire logic                                res_run_last,
  input wire logic                                res_run_empty
);

  // empty marker carries nothing else
  a_empty_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_run_empty |->
      res_position == '0 && res_filtered_value == '0 && !res_run_last)
    else $error("empty marker with nonzero fields");

  // a run beat closes the input side at once
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready && req_type == wlc_pkg::REQ_RUN |=> !req_ready)
    else $error("input ready right after a run beat");

  // a load beat never produces a result
  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready && req_type == wlc_pkg::REQ_LOAD && !res_valid |=> !res_valid)
    else $error("result after a load beat");

  // stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_position)
      && $stable(res_filtered_value) && $stable(res_run_last) && $stable(res_run_empty))
    else $error("stalled result changed");

endmodule

bind windowed_line_convolution wlc_checker u_wlc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .req_type           (req.req_type),
  .res_valid          (res.valid),
  .res_ready          (res.ready),
  .res_position       (res.position),
  .res_filtered_value (res.filtered_value),
  .res_run_last       (res.run_last),
  .res_run_empty      (res.run_empty)
);
`default_nettype wire

// ----- dv/testbench.sv -----
// self-checking testbench for the windowed line convolution block
`timescale 1ns / 1ps
module testbench;
  import wlc_pkg::*;

  typedef struct packed {
    logic                      req_type;
    logic [SAMPLE_W-1:0]       sample;
    logic                      last;
    logic signed [START_W-1:0] start;
    logic [WIDTH_W-1:0]        width;
  } line_req_t;

  typedef struct packed {
    logic [OUT_POS_W-1:0] position;
    logic [SAMPLE_W-1:0]  value;
    logic                 run_last;
    logic                 run_empty;
  } line_res_t;

  localparam int HOLD_CYCLES = 400;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  wlc_req_if req_ch ();
  wlc_res_if res_ch ();

  windowed_line_convolution dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req_ch),
    .res        (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  line_req_t req_backlog [$];
  line_res_t filtered_due [$];
  line_req_t on_bus;
  int send_idle_pct;
  int recv_idle_pct;
  int err_cnt;
  int queued_cnt;
  int gen_len;
  int hold_left;
  logic hold_request;
  logic hold_taken;

  // predictor state
  logic [SAMPLE_W-1:0] line_copy [LINE_MAX];
  int line_len;
  int load_ptr;
  logic [HW_W-1:0] kern_hw;
  logic [TAP_W-1:0] kern_tap [NUM_TAPS];

  task automatic convolve_request(input line_req_t r);
    int hw;
    int first;
    int stop;
    int w;
    int k;
    int count;
    longint unsigned acc;
    longint unsigned v;
    line_res_t prev;
    line_res_t cur;
    if (r.req_type == REQ_LOAD) begin
      if (load_ptr < LINE_MAX) begin
        line_copy[load_ptr] = r.sample;
        load_ptr++;
      end
      if (r.last) begin
        line_len = load_ptr;
        load_ptr = 0;
      end
    end else begin
      hw = (kern_hw > MAX_HW) ? MAX_HW : int'(kern_hw);
      w = (r.width > MAX_WINDOW) ? MAX_WINDOW : int'(r.width);
      first = int'($signed(r.start)) - hw;
      stop = int'($signed(r.start)) + hw + w;
      count = 0;
      prev = '0;
      for (int n = first; n < stop && n < line_len; n++) begin
        if (n < 0) continue;
        acc = 0;
        for (int d = -hw; d <= hw; d++) begin
          k = n + d;
          if (k >= 0 && k < line_len && k < LINE_MAX)
            acc += 64'(line_copy[k]) * 64'(kern_tap[d + MAX_HW]);
        end
        v = (acc + (64'd1 << (FRAC_SHIFT - 1))) >> FRAC_SHIFT;
        if (v > 64'hFFFF) v = 64'hFFFF;
        cur.position = OUT_POS_W'(n);
        cur.value = SAMPLE_W'(v);
        cur.run_last = 1'b0;
        cur.run_empty = 1'b0;
        if (count > 0) filtered_due.push_back(prev);
        prev = cur;
        count++;
      end
      if (count == 0) begin
        cur = '0;
        cur.run_empty = 1'b1;
        filtered_due.push_back(cur);
      end else begin
        prev.run_last = 1'b1;
        filtered_due.push_back(prev);
      end
    end
  endtask

  task automatic flag_error(input string what, input line_res_t want, input line_res_t got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("%0t %s: want pos %0d val %h last %b empty %b, got pos %0d val %h last %b empty %b",
               $time, what, want.position, want.value, want.run_last, want.run_empty,
               got.position, got.value, got.run_last, got.run_empty);
  endtask

  // request driver
  always @(posedge clk_i) begin
    logic offer;
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else begin
      offer = req_ch.valid;
      if (req_ch.valid && req_ch.ready) begin
        convolve_request(on_bus);
        offer = 1'b0;
      end
      if (!offer && req_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        on_bus = req_backlog.pop_front();
        req_ch.req_type <= on_bus.req_type;
        req_ch.sample_value <= on_bus.sample;
        req_ch.load_last <= on_bus.last;
        req_ch.window_start <= on_bus.start;
        req_ch.active_width <= on_bus.width;
        offer = 1'b1;
      end
      req_ch.valid <= offer;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    line_res_t got;
    line_res_t want;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got.position = res_ch.position;
        got.value = res_ch.filtered_value;
        got.run_last = res_ch.run_last;
        got.run_empty = res_ch.run_empty;
        if (filtered_due.size() == 0) begin
          flag_error("unexpected beat", '0, got);
        end else begin
          want = filtered_due.pop_front();
          if (got !== want) flag_error("mismatch", want, got);
        end
      end
      res_ch.ready <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // long result stall
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else if (hold_request && !hold_taken) begin
      hold_left <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7, 0))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [TAP_W-1:0] pick_tap();
    case ($urandom_range(9, 0))
      0: return '0;
      1: return TAP_ONE;
      2: return TAP_W'($urandom);
      default: return TAP_W'($urandom_range(32768, 0));
    endcase
  endfunction

  function automatic int pick_width();
    if ($urandom_range(9, 0) == 0) return $urandom_range(1, 0) ? 0 : $urandom_range(63, 49);
    return $urandom_range(MAX_WINDOW, 1);
  endfunction

  task automatic queue_load(input logic [SAMPLE_W-1:0] s, input logic last);
    line_req_t r;
    r.req_type = REQ_LOAD;
    r.sample = s;
    r.last = last;
    r.start = START_W'($urandom);
    r.width = WIDTH_W'($urandom);
    req_backlog.push_back(r);
    queued_cnt++;
  endtask

  task automatic queue_run(input int s, input int w);
    line_req_t r;
    r.req_type = REQ_RUN;
    r.sample = SAMPLE_W'($urandom);
    r.last = 1'($urandom);
    r.start = START_W'(s);
    r.width = WIDTH_W'(w);
    req_backlog.push_back(r);
    queued_cnt++;
  endtask

  task automatic queue_line(input int n);
    for (int i = 0; i < n; i++) queue_load(pick_sample(), i == n - 1);
    gen_len = (n > LINE_MAX) ? LINE_MAX : n;
  endtask

  task automatic queue_runs_near(input int count);
    for (int i = 0; i < count; i++)
      queue_run($urandom_range(gen_len + 6, 0) - 8, pick_width());
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    if (idx == CFG_HALF_WIDTH) kern_hw = data[HW_W-1:0];
    else kern_tap[idx - CFG_TAP_MINUS3] = data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_kernel(input int hw, input logic [TAP_W-1:0] tap);
    write_reg(CFG_HALF_WIDTH, CFG_DATA_W'(hw));
    for (int j = 0; j < NUM_TAPS; j++) write_reg(CFG_TAP_MINUS3 + CFG_IDX_W'(j), tap);
  endtask

  // negative hw picks a random half width
  task automatic shuffle_kernel(input int hw);
    write_reg(CFG_HALF_WIDTH, CFG_DATA_W'((hw < 0) ? $urandom_range(MAX_HW, 0) : hw));
    for (int j = 0; j < NUM_TAPS; j++) write_reg(CFG_TAP_MINUS3 + CFG_IDX_W'(j), pick_tap());
  endtask

  task automatic settle();
    do @(negedge clk_i);
    while (req_backlog.size() != 0 || req_ch.valid || filtered_due.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic random_action();
    case ($urandom_range(9, 0))
      0, 1, 2, 3: begin
        queue_line(($urandom_range(7, 0) == 0) ? $urandom_range(150, 41) : $urandom_range(40, 1));
        queue_runs_near($urandom_range(3, 1));
      end
      4, 5: queue_runs_near(1);
      6: begin
        // run while a new line is half loaded
        repeat ($urandom_range(6, 1)) queue_load(pick_sample(), 1'b0);
        queue_runs_near(1);
      end
      7: queue_run($urandom_range(1023, 0) - 512, $urandom_range(63, 0));
      8: queue_load(pick_sample(), 1'($urandom));
      default: queue_runs_near(2);
    endcase
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    logic [SAMPLE_W-1:0] s;
    int mark;
    int round_mark;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_LOAD;
    req_ch.sample_value = '0;
    req_ch.load_last = 1'b0;
    req_ch.window_start = '0;
    req_ch.active_width = '0;
    res_ch.ready = 1'b0;
    hold_request = 1'b0;
    err_cnt = 0;
    queued_cnt = 0;
    gen_len = 0;
    kern_hw = '0;
    for (int j = 0; j < NUM_TAPS; j++) kern_tap[j] = (j == MAX_HW) ? TAP_ONE : '0;
    for (int i = 0; i < LINE_MAX; i++) line_copy[i] = '0;
    line_len = 0;
    load_ptr = 0;
    send_idle_pct = 22;
    recv_idle_pct = 55;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset kernel: empty line, extremes of the window fields
    queue_run(0, 1);
    for (int i = 0; i < 16; i++) begin
      case (i)
        0: s = '1;
        1: s = '0;
        2: s = 16'h8000;
        3: s = 16'h0001;
        default: s = pick_sample();
      endcase
      queue_load(s, i == 15);
    end
    gen_len = 16;
    queue_run(0, 1);
    queue_run(-64, 1);
    queue_run(511, 1);
    queue_run(-3, 6);
    queue_run(10, 63);
    queue_run(0, 0);
    queue_run(-512, 5);
    queue_run(15, 1);
    settle();

    // widest kernel at full weight saturates
    set_kernel(MAX_HW, TAP_ONE);
    queue_run(0, MAX_WINDOW);
    queue_run(14, 1);
    repeat (4) queue_load(pick_sample(), 1'b0);
    queue_run(0, 8);
    queue_load(16'hFFFF, 1'b1);
    queue_run(-2, 3);
    queue_run(4, 0);
    settle();
    set_kernel(2, '0);
    queue_run(0, 10);
    settle();

    // line longer than the store
    shuffle_kernel(MAX_HW);
    queue_line(LINE_MAX + 3);
    queue_run(200, MAX_WINDOW);
    queue_run(505, MAX_WINDOW);
    queue_run(511, 1);
    queue_run(-3, MAX_WINDOW);
    settle();

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 22 : (mode == 1) ? 55 : 0;
      recv_idle_pct = (mode == 0) ? 55 : (mode == 1) ? 22 : 0;
      mark = queued_cnt;
      while (queued_cnt - mark < 100) begin
        settle();
        shuffle_kernel(-1);
        if (mode == 0) hold_request <= 1'b1;
        round_mark = queued_cnt;
        while (queued_cnt - round_mark < 40) random_action();
      end
    end

    settle();
    repeat (600) @(posedge clk_i);
    if (filtered_due.size() != 0) $display("%0d expected beats never arrived", filtered_due.size());
    if (err_cnt == 0 && filtered_due.size() == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/wlc_pkg.sv
sv/wlc_if.sv
sv/wlc_line_mem.sv
sv/wlc_mac.sv
sv/windowed_line_convolution.sv
sv/wlc_checker.sv
dv/testbench.sv
